FILE: src/bfa_pkg.sv
// Shared types and codes for the boundary tag first-fit allocator.
`timescale 1ns / 1ps
`default_nettype none
package bfa_pkg;

  localparam int ARENA_BYTES  = 4096;
  localparam int HEADER_BYTES = 16;
  localparam int HANDLE_COUNT = 64;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_REALLOC = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOMEM     = 2'd1,
    ST_BADHANDLE = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_HT,
    S_FR_RD,
    S_FR_EV,
    S_RA_RD,
    S_RA_EV,
    S_RA_NX_RD,
    S_RA_NX_EV,
    S_RA_SPL,
    S_RA_W,
    S_SLOT,
    S_FT_RD,
    S_FT_EV,
    S_TK_SPL,
    S_TK_W,
    S_REL,
    S_CO_A_RD,
    S_CO_A_EV,
    S_CO_RD,
    S_CO_EV,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: src/boundary_tag_first_fit_allocator_unit.sv
// Top level of the boundary tag first-fit allocator.
`timescale 1ns / 1ps
`default_nettype none
// Heap allocator over an arena of ARENA_BYTES bytes tiled by a chain of
// headers kept in a RAM indexed by byte offset, plus a handle table RAM and
// per-handle valid flops. One command is worked at a time by a small
// sequencer; in_ready is high only while idle. Each header visited in a chain
// walk is a registered RAM read followed by an evaluate state. Alloc scans up
// to HANDLE_COUNT handles for a free slot, then walks the header chain; free
// runs a merge pass that always walks the full chain of headers in the arena;
// a moving realloc does the work of an alloc and a free. After reset the
// S_INIT state seeds the first header before the first command is taken. A
// finished result sits in an output register so the next command can be
// accepted while it waits.
module boundary_tag_first_fit_allocator_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [5:0]  in_handle,
  input  wire logic [12:0] in_request_bytes,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [5:0]       out_result_handle,
  output logic [11:0]      out_payload_offset,
  output logic             out_copy_needed,
  output logic [11:0]      out_copy_from_offset,
  output logic [12:0]      out_copy_length
);
  import bfa_pkg::*;

  localparam int OFF_W = $clog2(ARENA_BYTES);
  localparam int SZ_W  = $clog2(ARENA_BYTES + 1);
  localparam int AW    = (OFF_W + 2 > 14) ? OFF_W + 2 : 14;
  localparam int HW    = $clog2(HANDLE_COUNT);
  localparam int CW    = $clog2(HANDLE_COUNT + 1);
  localparam int EW    = SZ_W + 1;

  localparam logic [AW-1:0]  HDR   = AW'(HEADER_BYTES);
  localparam logic [AW-1:0]  ARENA = AW'(ARENA_BYTES);
  localparam logic [SZ_W-1:0] INIT_SZ = SZ_W'(ARENA_BYTES - HEADER_BYTES);
  localparam logic [HW-1:0]  HLAST = HW'(HANDLE_COUNT - 1);
  localparam logic [CW-1:0]  CLAST = CW'(HANDLE_COUNT - 1);

  state_t state_r, state_nxt;

  logic [1:0]      cmd_r, cmd_nxt;
  logic [5:0]      h_r, h_nxt;
  logic [12:0]     n_r, n_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [SZ_W-1:0] old_r, old_nxt;
  logic            moving_r, moving_nxt;
  logic [HW-1:0]   slot_r, slot_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [HW-1:0]   nh_r, nh_nxt;
  logic [HANDLE_COUNT-1:0] valid_r, valid_nxt;
  logic [AW-1:0]   walk_r, walk_nxt;
  logic [OFF_W-1:0] a_r, a_nxt;
  logic [SZ_W-1:0] sa_r, sa_nxt;
  logic            fa_r, fa_nxt;
  logic [SZ_W-1:0] fsz_r, fsz_nxt;
  logic [AW-1:0]   tot_r, tot_nxt;

  logic [1:0]  res_status_r, res_status_nxt;
  logic [5:0]  res_handle_r, res_handle_nxt;
  logic [11:0] res_pay_r, res_pay_nxt;
  logic        res_cp_r, res_cp_nxt;
  logic [11:0] res_from_r, res_from_nxt;
  logic [12:0] res_len_r, res_len_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r;
  logic [5:0]  out_handle_r;
  logic [11:0] out_pay_r;
  logic        out_cp_r;
  logic [11:0] out_from_r;
  logic [12:0] out_len_r;
  logic        out_load;

  // header RAM and handle table RAM
  logic             mem_we;
  logic [OFF_W-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0]    mem_wdata, mem_rdata;
  logic             ht_we;
  logic [OFF_W-1:0] ht_rdata;

  logic            rd_free;
  logic [AW-1:0]   rd_size;
  logic [AW-1:0]   n_w, old_w, sa_w, off_w, a_w;
  logic            known;
  logic [HW-1:0]   slot_inc;

  assign rd_free  = mem_rdata[SZ_W];
  assign rd_size  = AW'(mem_rdata[SZ_W-1:0]);
  assign n_w      = AW'(n_r);
  assign old_w    = AW'(old_r);
  assign sa_w     = AW'(sa_r);
  assign off_w    = AW'(off_r);
  assign a_w      = AW'(a_r);
  assign known    = (32'(h_r) < HANDLE_COUNT) && valid_r[HW'(h_r)];
  assign slot_inc = (slot_r == HLAST) ? '0 : slot_r + 1'b1;
  assign in_ready = (state_r == S_IDLE);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  bfa_ram #(.WIDTH(EW), .DEPTH(ARENA_BYTES)) u_hdr_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bfa_ram #(.WIDTH(OFF_W), .DEPTH(HANDLE_COUNT)) u_ht_ram (
    .clk   (clk),
    .we    (ht_we),
    .waddr (slot_r),
    .wdata (walk_r[OFF_W-1:0]),
    .raddr (HW'(in_handle)),
    .rdata (ht_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: state_nxt = S_IDLE;
      S_IDLE: if (in_valid) state_nxt = S_HT;
      S_HT: begin
        unique case (cmd_r)
          CMD_ALLOC:   state_nxt = S_SLOT;
          CMD_FREE:    state_nxt = known ? S_FR_RD : S_DONE;
          CMD_REALLOC: state_nxt = known ? S_RA_RD : S_SLOT;
          default:     state_nxt = S_DONE;
        endcase
      end
      S_FR_RD: state_nxt = S_FR_EV;
      S_FR_EV: state_nxt = S_CO_A_RD;
      S_RA_RD: state_nxt = S_RA_EV;
      S_RA_EV: state_nxt = (off_w + HDR + rd_size + HDR <= ARENA) ? S_RA_NX_RD : S_SLOT;
      S_RA_NX_RD: state_nxt = S_RA_NX_EV;
      S_RA_NX_EV: begin
        if (rd_free && (rd_size + old_w + HDR >= n_w)) begin
          state_nxt = (rd_size + old_w + HDR - n_w > (HDR << 1)) ? S_RA_SPL : S_RA_W;
        end else begin
          state_nxt = S_SLOT;
        end
      end
      S_RA_SPL: state_nxt = S_RA_W;
      S_RA_W:   state_nxt = S_DONE;
      S_SLOT: begin
        if (!valid_r[slot_r]) state_nxt = S_FT_RD;
        else if (cnt_r == CLAST) state_nxt = S_DONE;
      end
      S_FT_RD: state_nxt = (walk_r + HDR <= ARENA) ? S_FT_EV : S_DONE;
      S_FT_EV: begin
        if (rd_free && rd_size >= n_w) begin
          state_nxt = (rd_size > n_w + HDR) ? S_TK_SPL : S_TK_W;
        end else begin
          state_nxt = S_FT_RD;
        end
      end
      S_TK_SPL:  state_nxt = S_TK_W;
      S_TK_W:    state_nxt = moving_r ? S_REL : S_DONE;
      S_REL:     state_nxt = S_CO_A_RD;
      S_CO_A_RD: state_nxt = S_CO_A_EV;
      S_CO_A_EV: state_nxt = S_CO_RD;
      S_CO_RD:   state_nxt = (walk_r + HDR <= ARENA) ? S_CO_EV : S_DONE;
      S_CO_EV:   state_nxt = S_CO_RD;
      S_DONE:    if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default:   state_nxt = S_INIT;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cmd_nxt = cmd_r; h_nxt = h_r; n_nxt = n_r; off_nxt = off_r; old_nxt = old_r;
    moving_nxt = moving_r; slot_nxt = slot_r; cnt_nxt = cnt_r; nh_nxt = nh_r;
    valid_nxt = valid_r; walk_nxt = walk_r; a_nxt = a_r; sa_nxt = sa_r;
    fa_nxt = fa_r; fsz_nxt = fsz_r; tot_nxt = tot_r;
    res_status_nxt = res_status_r; res_handle_nxt = res_handle_r;
    res_pay_nxt = res_pay_r; res_cp_nxt = res_cp_r;
    res_from_nxt = res_from_r; res_len_nxt = res_len_r;
    mem_we = 1'b0; mem_waddr = '0; mem_wdata = '0; mem_raddr = '0; ht_we = 1'b0;
    unique case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = {1'b1, INIT_SZ};
      end
      S_IDLE: begin
        cmd_nxt = in_command;
        h_nxt   = in_handle;
        n_nxt   = in_request_bytes;
      end
      S_HT: begin
        off_nxt        = ht_rdata;
        moving_nxt     = 1'b0;
        slot_nxt       = nh_r;
        cnt_nxt        = '0;
        res_status_nxt = ST_BADHANDLE;
        res_handle_nxt = h_r;
        res_pay_nxt    = '0;
        res_cp_nxt     = 1'b0;
        res_from_nxt   = '0;
        res_len_nxt    = '0;
      end
      S_FR_RD: mem_raddr = off_r;
      S_FR_EV: begin
        mem_we    = 1'b1;
        mem_waddr = off_r;
        mem_wdata = {1'b1, mem_rdata[SZ_W-1:0]};
        valid_nxt[HW'(h_r)] = 1'b0;
        res_status_nxt = ST_OK;
        res_pay_nxt    = 12'(off_w + HDR);
      end
      S_RA_RD: mem_raddr = off_r;
      S_RA_EV: begin
        old_nxt    = mem_rdata[SZ_W-1:0];
        walk_nxt   = off_w + HDR + rd_size;
        moving_nxt = 1'b1;
      end
      S_RA_NX_RD: mem_raddr = walk_r[OFF_W-1:0];
      S_RA_NX_EV: tot_nxt = rd_size + old_w + HDR;
      S_RA_SPL: begin
        // split the tail off as a free block, shrink to the request
        mem_we    = 1'b1;
        mem_waddr = OFF_W'(off_w + HDR + n_w);
        mem_wdata = {1'b1, SZ_W'(tot_r - n_w - HDR)};
        tot_nxt   = n_w;
      end
      S_RA_W: begin
        mem_we    = 1'b1;
        mem_waddr = off_r;
        mem_wdata = {1'b0, SZ_W'(tot_r)};
        res_status_nxt = ST_OK;
        res_pay_nxt    = 12'(off_w + HDR);
      end
      S_SLOT: begin
        walk_nxt = '0;
        if (valid_r[slot_r]) begin
          if (cnt_r == CLAST) begin
            res_status_nxt = ST_FULL;
            res_handle_nxt = '0;
          end else begin
            cnt_nxt  = cnt_r + 1'b1;
            slot_nxt = slot_inc;
          end
        end
      end
      S_FT_RD: begin
        mem_raddr = walk_r[OFF_W-1:0];
        if (!(walk_r + HDR <= ARENA)) begin
          res_status_nxt = ST_NOMEM;
          res_handle_nxt = '0;
        end
      end
      S_FT_EV: begin
        fsz_nxt = mem_rdata[SZ_W-1:0];
        if (!(rd_free && rd_size >= n_w)) walk_nxt = walk_r + HDR + rd_size;
      end
      S_TK_SPL: begin
        mem_we    = 1'b1;
        mem_waddr = OFF_W'(walk_r + HDR + n_w);
        mem_wdata = {1'b1, SZ_W'(AW'(fsz_r) - n_w - HDR)};
        fsz_nxt   = SZ_W'(n_w);
      end
      S_TK_W: begin
        mem_we    = 1'b1;
        mem_waddr = walk_r[OFF_W-1:0];
        mem_wdata = {1'b0, fsz_r};
        ht_we     = 1'b1;
        valid_nxt[slot_r] = 1'b1;
        nh_nxt    = slot_inc;
        res_status_nxt = ST_OK;
        res_handle_nxt = 6'(slot_r);
        res_pay_nxt    = 12'(walk_r + HDR);
        if (moving_r) begin
          res_cp_nxt   = 1'b1;
          res_from_nxt = 12'(off_w + HDR);
          res_len_nxt  = 13'(old_r);
        end
      end
      S_REL: begin
        mem_we    = 1'b1;
        mem_waddr = off_r;
        mem_wdata = {1'b1, old_r};
        valid_nxt[HW'(h_r)] = 1'b0;
      end
      S_CO_A_RD: mem_raddr = '0;
      S_CO_A_EV: begin
        a_nxt    = '0;
        sa_nxt   = mem_rdata[SZ_W-1:0];
        fa_nxt   = rd_free;
        walk_nxt = HDR + rd_size;
      end
      S_CO_RD: mem_raddr = walk_r[OFF_W-1:0];
      S_CO_EV: begin
        if (fa_r && rd_free) begin
          // absorb the next block into the current free run
          sa_nxt    = SZ_W'(sa_w + HDR + rd_size);
          mem_we    = 1'b1;
          mem_waddr = a_r;
          mem_wdata = {1'b1, SZ_W'(sa_w + HDR + rd_size)};
          walk_nxt  = a_w + HDR + sa_w + HDR + rd_size;
        end else begin
          a_nxt    = walk_r[OFF_W-1:0];
          sa_nxt   = mem_rdata[SZ_W-1:0];
          fa_nxt   = rd_free;
          walk_nxt = walk_r + HDR + rd_size;
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      valid_r     <= '0;
      nh_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      nh_r        <= nh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt; h_r <= h_nxt; n_r <= n_nxt; off_r <= off_nxt; old_r <= old_nxt;
    moving_r <= moving_nxt; slot_r <= slot_nxt; cnt_r <= cnt_nxt; walk_r <= walk_nxt;
    a_r <= a_nxt; sa_r <= sa_nxt; fa_r <= fa_nxt; fsz_r <= fsz_nxt; tot_r <= tot_nxt;
    res_status_r <= res_status_nxt; res_handle_r <= res_handle_nxt;
    res_pay_r <= res_pay_nxt; res_cp_r <= res_cp_nxt;
    res_from_r <= res_from_nxt; res_len_r <= res_len_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_handle_r <= res_handle_r;
      out_pay_r    <= res_pay_r;
      out_cp_r     <= res_cp_r;
      out_from_r   <= res_from_r;
      out_len_r    <= res_len_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_result_handle    = out_handle_r;
  assign out_payload_offset   = out_pay_r;
  assign out_copy_needed      = out_cp_r;
  assign out_copy_from_offset = out_from_r;
  assign out_copy_length      = out_len_r;

  a_co_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CO_EV) |-> (a_w < walk_r))
    else $error("merge pass lost its ordering");

  a_fit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FT_EV) |-> (walk_r < ARENA))
    else $error("fit walk ran past the arena");

  a_take_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TK_W) |-> !valid_r[slot_r])
    else $error("handle issued while in use");

endmodule
`default_nettype wire

FILE: src/bfa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
